// ----- rtl/stbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stbc_pkg: shared types and codes for the socket target bypass classifier
// Holds request, family and verdict codes and the structs that pass
// between the decode, table and top-level logic.
// ----------------------------------------------------------------------------
package stbc_pkg;

  // request codes
  localparam logic REQ_CLASSIFY = 1'b0;
  localparam logic REQ_WRITE    = 1'b1;

  // address family codes
  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  // verdict codes
  localparam logic [1:0] VERDICT_PROXY   = 2'd0;
  localparam logic [1:0] VERDICT_UNSUP   = 2'd1;
  localparam logic [1:0] VERDICT_MATCH   = 2'd2;
  localparam logic [1:0] VERDICT_WRITE   = 2'd3;

  // word 2 of an ipv4-mapped ipv6 address
  localparam logic [31:0] MAPPED_MARK = 32'h0000_ffff;

  // table slot write request
  typedef struct packed {
    logic        en;
    logic [2:0]  index;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [15:0] port;
    logic        valid;
  } stbc_wr_t;

  // decoded connection target
  typedef struct packed {
    logic        unsupported;
    logic        is_ipv4;
    logic [31:0] target;
  } stbc_target_t;

endpackage
`default_nettype wire

// ----- rtl/stbc_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stbc_decode: target address decode
// Sorts the family, reduces ipv4-mapped ipv6 addresses and picks out the
// ipv4 target that the table is searched with.
// ----------------------------------------------------------------------------
module stbc_decode (
  input  wire logic [1:0]            family,
  input  wire logic [31:0]           addr_w0,
  input  wire logic [31:0]           addr_w1,
  input  wire logic [31:0]           addr_w2,
  input  wire logic [31:0]           addr_w3,
  output stbc_pkg::stbc_target_t     tgt
);
  import stbc_pkg::*;

  logic mapped;

  // ::ffff:a.b.c.d form
  assign mapped = (addr_w0 == 32'd0) && (addr_w1 == 32'd0) && (addr_w2 == MAPPED_MARK);

  // family sort and target pick
  always_comb begin
    tgt.unsupported = 1'b0;
    tgt.is_ipv4     = 1'b0;
    tgt.target      = 32'd0;
    unique case (family)
      FAM_IPV4: begin
        tgt.is_ipv4 = 1'b1;
        tgt.target  = addr_w0;
      end
      FAM_IPV6: begin
        tgt.is_ipv4 = mapped;
        tgt.target  = mapped ? addr_w3 : 32'd0;
      end
      default: begin
        tgt.unsupported = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/stbc_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stbc_table: bypass network table
// Register table of network entries with per-slot valid bits, written one
// slot at a time and compared against a target in parallel.
// ----------------------------------------------------------------------------
module stbc_table #(
  parameter int ENTRIES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire stbc_pkg::stbc_wr_t  wr,
  input  wire logic [31:0]         target,
  input  wire logic [15:0]         tport,
  output logic                     hit
);
  import stbc_pkg::*;

  logic [31:0]        addr_r  [ENTRIES];
  logic [31:0]        mask_r  [ENTRIES];
  logic [15:0]        port_r  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [ENTRIES-1:0] sel;
  logic [ENTRIES-1:0] match;

  // slot select, writes beyond the table select nothing
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sel[i] = wr.en && (int'(wr.index) == i);
    end
  end

  // valid bits
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) valid_nxt[i] = wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        addr_r[i] <= wr.addr;
        mask_r[i] <= wr.mask;
        port_r[i] <= wr.port;
      end
    end
  end

  // parallel masked compare per slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (((target ^ addr_r[i]) & mask_r[i]) == 32'd0) &&
                 ((port_r[i] == 16'd0) || (port_r[i] == tport));
    end
  end

  assign hit = |match;

endmodule
`default_nettype wire

// ----- rtl/socket_target_bypass_classifier.sv -----
`default_nettype none
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// A table write takes effect for the word right behind it.
// Reset (synchronous, rst_n low) empties both registers and clears all
// table valid bits; entry contents are kept and read only once rewritten.
// ----------------------------------------------------------------------------
// socket_target_bypass_classifier: proxy bypass classifier
// Decodes a connection target, matches ipv4 targets against a table of
// network entries and reports bypass and verdict; write words load entries.
// ----------------------------------------------------------------------------
module socket_target_bypass_classifier #(
  parameter int ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [1:0]  in_family,
  input  wire logic [31:0] in_addr_w0,
  input  wire logic [31:0] in_addr_w1,
  input  wire logic [31:0] in_addr_w2,
  input  wire logic [31:0] in_addr_w3,
  input  wire logic [15:0] in_port,
  input  wire logic [2:0]  in_entry_index,
  input  wire logic [31:0] in_entry_addr,
  input  wire logic [31:0] in_entry_mask,
  input  wire logic [15:0] in_entry_port,
  input  wire logic        in_entry_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_bypass,
  output logic [1:0]       out_verdict,
  output logic             out_is_ipv6,
  output logic [31:0]      out_ipv4_target,
  output logic [15:0]      out_port_out
);
  import stbc_pkg::*;

  // input register
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_req_r;
  logic [1:0]  s1_family_r;
  logic [31:0] s1_w0_r;
  logic [31:0] s1_w1_r;
  logic [31:0] s1_w2_r;
  logic [31:0] s1_w3_r;
  logic [15:0] s1_port_r;
  logic [2:0]  s1_eidx_r;
  logic [31:0] s1_eaddr_r;
  logic [31:0] s1_emask_r;
  logic [15:0] s1_eport_r;
  logic        s1_evalid_r;

  // result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        bypass_r;
  logic        bypass_nxt;
  logic [1:0]  verdict_r;
  logic [1:0]  verdict_nxt;
  logic        is_ipv6_r;
  logic        is_ipv6_nxt;
  logic [31:0] ipv4_r;
  logic [31:0] ipv4_nxt;
  logic [15:0] port_out_r;
  logic [15:0] port_out_nxt;

  logic         out_free;
  logic         in_take;
  logic         hit;
  stbc_target_t tgt;
  stbc_wr_t     wr;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r    <= in_req_type;
      s1_family_r <= in_family;
      s1_w0_r     <= in_addr_w0;
      s1_w1_r     <= in_addr_w1;
      s1_w2_r     <= in_addr_w2;
      s1_w3_r     <= in_addr_w3;
      s1_port_r   <= in_port;
      s1_eidx_r   <= in_entry_index;
      s1_eaddr_r  <= in_entry_addr;
      s1_emask_r  <= in_entry_mask;
      s1_eport_r  <= in_entry_port;
      s1_evalid_r <= in_entry_valid;
    end
  end

  // target decode
  stbc_decode u_decode (
    .family  (s1_family_r),
    .addr_w0 (s1_w0_r),
    .addr_w1 (s1_w1_r),
    .addr_w2 (s1_w2_r),
    .addr_w3 (s1_w3_r),
    .tgt     (tgt)
  );

  // table write as the word leaves the input register
  always_comb begin
    wr.en    = s1_valid_r && out_free && (s1_req_r == REQ_WRITE);
    wr.index = s1_eidx_r;
    wr.addr  = s1_eaddr_r;
    wr.mask  = s1_emask_r;
    wr.port  = s1_eport_r;
    wr.valid = s1_evalid_r;
  end

  stbc_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .target (tgt.target),
    .tport  (s1_port_r),
    .hit    (hit)
  );

  // result build
  always_comb begin
    bypass_nxt   = 1'b0;
    verdict_nxt  = VERDICT_PROXY;
    is_ipv6_nxt  = 1'b0;
    ipv4_nxt     = 32'd0;
    port_out_nxt = 16'd0;
    if (s1_req_r == REQ_WRITE) begin
      verdict_nxt = VERDICT_WRITE;
    end else if (tgt.unsupported) begin
      bypass_nxt  = 1'b1;
      verdict_nxt = VERDICT_UNSUP;
    end else begin
      port_out_nxt = s1_port_r;
      if (tgt.is_ipv4) begin
        ipv4_nxt = tgt.target;
        if (hit) begin
          bypass_nxt  = 1'b1;
          verdict_nxt = VERDICT_MATCH;
        end
      end else begin
        is_ipv6_nxt = 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      bypass_r   <= bypass_nxt;
      verdict_r  <= verdict_nxt;
      is_ipv6_r  <= is_ipv6_nxt;
      ipv4_r     <= ipv4_nxt;
      port_out_r <= port_out_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bypass      = bypass_r;
  assign out_verdict     = verdict_r;
  assign out_is_ipv6     = is_ipv6_r;
  assign out_ipv4_target = ipv4_r;
  assign out_port_out    = port_out_r;

  // checks
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_stall |=> out_valid_r)
    else $error("input word did not advance to result register");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (verdict_r == VERDICT_WRITE) |->
      !bypass_r && !is_ipv6_r && (ipv4_r == 32'd0) && (port_out_r == 16'd0))
    else $error("write word result carries target data");

  a_bypass_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (bypass_r == ((verdict_r == VERDICT_UNSUP) || (verdict_r == VERDICT_MATCH))))
    else $error("bypass disagrees with verdict");

  a_ipv6_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && is_ipv6_r |-> (verdict_r == VERDICT_PROXY) && (ipv4_r == 32'd0))
    else $error("ipv6 target with ipv4 result");

endmodule
`default_nettype wire

// ----- verif/socket_target_bypass_classifier_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// socket_target_bypass_classifier_tb: self-checking bench for the classifier
// Feeds classify and table write words through the valid/stall input port,
// predicts each verdict from a local copy of the bypass table and compares
// every result word field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module socket_target_bypass_classifier_tb;
  import stbc_pkg::*;

  localparam int ACL_ENTRIES = 8;
  localparam int RAND_WORDS  = 1750;
  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int TAIL_WORDS  = 200;

  // family codes outside ipv4 and ipv6
  localparam logic [1:0] FAM_OTHER = 2'd2;
  localparam logic [1:0] FAM_RSVD  = 2'd3;

  typedef struct {
    logic        req_type;
    logic [1:0]  family;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [15:0] port;
    logic [2:0]  idx;
    logic [31:0] e_addr;
    logic [31:0] e_mask;
    logic [15:0] e_port;
    logic        e_valid;
  } target_word_t;

  typedef struct {
    logic        bypass;
    logic [1:0]  verdict;
    logic        is_ipv6;
    logic [31:0] ipv4_target;
    logic [15:0] port_out;
  } verdict_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_req_type    = 1'b0;
  logic [1:0]  in_family      = 2'd0;
  logic [31:0] in_addr_w0     = 32'h0;
  logic [31:0] in_addr_w1     = 32'h0;
  logic [31:0] in_addr_w2     = 32'h0;
  logic [31:0] in_addr_w3     = 32'h0;
  logic [15:0] in_port        = 16'h0;
  logic [2:0]  in_entry_index = 3'd0;
  logic [31:0] in_entry_addr  = 32'h0;
  logic [31:0] in_entry_mask  = 32'h0;
  logic [15:0] in_entry_port  = 16'h0;
  logic        in_entry_valid = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_bypass;
  logic [1:0]  out_verdict;
  logic        out_is_ipv6;
  logic [31:0] out_ipv4_target;
  logic [15:0] out_port_out;

  socket_target_bypass_classifier #(
    .ENTRIES(ACL_ENTRIES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_family      (in_family),
    .in_addr_w0     (in_addr_w0),
    .in_addr_w1     (in_addr_w1),
    .in_addr_w2     (in_addr_w2),
    .in_addr_w3     (in_addr_w3),
    .in_port        (in_port),
    .in_entry_index (in_entry_index),
    .in_entry_addr  (in_entry_addr),
    .in_entry_mask  (in_entry_mask),
    .in_entry_port  (in_entry_port),
    .in_entry_valid (in_entry_valid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bypass     (out_bypass),
    .out_verdict    (out_verdict),
    .out_is_ipv6    (out_is_ipv6),
    .out_ipv4_target(out_ipv4_target),
    .out_port_out   (out_port_out)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  target_word_t word_q[$];
  verdict_t     verdict_q[$];
  int           err_cnt = 0;

  // bypass table as the block should hold it, updated at acceptance
  logic [31:0] acl_addr [ACL_ENTRIES];
  logic [31:0] acl_mask [ACL_ENTRIES];
  logic [15:0] acl_port [ACL_ENTRIES];
  logic        acl_valid[ACL_ENTRIES];

  // table as planned at generation, only used to aim targets at entries
  logic [31:0] plan_addr [ACL_ENTRIES];
  logic [31:0] plan_mask [ACL_ENTRIES];
  logic [15:0] plan_port [ACL_ENTRIES];
  logic        plan_valid[ACL_ENTRIES];

  initial begin
    for (int i = 0; i < ACL_ENTRIES; i++) begin
      acl_valid[i]  = 1'b0;
      plan_valid[i] = 1'b0;
    end
  end

  // verdict for one accepted word; write words update the table
  function automatic verdict_t predict_verdict(target_word_t w);
    verdict_t    r;
    logic [31:0] tgt;
    logic        v4;
    r.bypass      = 1'b0;
    r.verdict     = VERDICT_PROXY;
    r.is_ipv6     = 1'b0;
    r.ipv4_target = 32'h0;
    r.port_out    = 16'h0;
    if (w.req_type == REQ_WRITE) begin
      if (int'(w.idx) < ACL_ENTRIES) begin
        acl_addr[w.idx]  = w.e_addr;
        acl_mask[w.idx]  = w.e_mask;
        acl_port[w.idx]  = w.e_port;
        acl_valid[w.idx] = w.e_valid;
      end
      r.verdict = VERDICT_WRITE;
    end else if (w.family != FAM_IPV4 && w.family != FAM_IPV6) begin
      r.bypass  = 1'b1;
      r.verdict = VERDICT_UNSUP;
    end else begin
      v4  = 1'b1;
      tgt = w.w0;
      // ::ffff:a.b.c.d reduces to ipv4, any other ipv6 stays ipv6
      if (w.family == FAM_IPV6) begin
        if (w.w0 == 32'h0 && w.w1 == 32'h0 && w.w2 == MAPPED_MARK) tgt = w.w3;
        else v4 = 1'b0;
      end
      r.port_out = w.port;
      if (v4) begin
        r.ipv4_target = tgt;
        for (int i = 0; i < ACL_ENTRIES; i++) begin
          if (acl_valid[i] && ((tgt & acl_mask[i]) == (acl_addr[i] & acl_mask[i])) &&
              (acl_port[i] == 16'h0 || acl_port[i] == w.port)) begin
            r.bypass  = 1'b1;
            r.verdict = VERDICT_MATCH;
          end
        end
      end else begin
        r.is_ipv6 = 1'b1;
      end
    end
    return r;
  endfunction

  // queue a classify word; write-only fields carry random noise
  function automatic void add_classify(logic [1:0] fam, logic [31:0] w0, logic [31:0] w1,
                                       logic [31:0] w2, logic [31:0] w3, logic [15:0] p);
    target_word_t w;
    w.req_type = REQ_CLASSIFY;
    w.family   = fam;
    w.w0       = w0;
    w.w1       = w1;
    w.w2       = w2;
    w.w3       = w3;
    w.port     = p;
    w.idx      = 3'($urandom);
    w.e_addr   = $urandom;
    w.e_mask   = $urandom;
    w.e_port   = 16'($urandom);
    w.e_valid  = 1'($urandom);
    word_q.push_back(w);
  endfunction

  // queue a table write word; target fields carry random noise
  function automatic void add_write(logic [2:0] idx, logic [31:0] a, logic [31:0] m,
                                    logic [15:0] p, logic v);
    target_word_t w;
    w.req_type = REQ_WRITE;
    w.family   = 2'($urandom);
    w.w0       = $urandom;
    w.w1       = $urandom;
    w.w2       = $urandom;
    w.w3       = $urandom;
    w.port     = 16'($urandom);
    w.idx      = idx;
    w.e_addr   = a;
    w.e_mask   = m;
    w.e_port   = p;
    w.e_valid  = v;
    plan_addr[idx]  = a;
    plan_mask[idx]  = m;
    plan_port[idx]  = p;
    plan_valid[idx] = v;
    word_q.push_back(w);
  endfunction

  // mostly prefix masks, sometimes an arbitrary bit pattern
  function automatic logic [31:0] rand_mask();
    int len;
    if ($urandom_range(0, 5) == 0) return $urandom;
    len = $urandom_range(0, 32);
    if (len == 0) return 32'h0;
    return 32'hffff_ffff << (32 - len);
  endfunction

  // target aimed inside a planned entry, with port and bit near misses
  function automatic void aim_target(output logic [31:0] t, output logic [15:0] p);
    int slot;
    t = $urandom;
    p = 16'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      slot = $urandom_range(0, ACL_ENTRIES - 1);
      if (plan_valid[slot]) begin
        t = (plan_addr[slot] & plan_mask[slot]) | (t & ~plan_mask[slot]);
        if (plan_port[slot] != 16'h0 && $urandom_range(0, 3) != 0) p = plan_port[slot];
        if ($urandom_range(0, 5) == 0) t = t ^ (32'h1 << $urandom_range(0, 31));
      end
    end
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // shared pacing flags, written with nonblocking assignments only
  logic tail_mode = 1'b0;
  int   hold_left = 0;

  // driver: offers queued words, random gaps between them
  int           in_taken = 0;
  int           send_gap = 0;
  target_word_t cur_word;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(predict_verdict(cur_word));
        in_taken++;
      end
      tail_mode <= (word_q.size() < TAIL_WORDS);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_mode && hold_left == 0 && ((in_taken / 150) % 4 != 3) &&
                     $urandom_range(0, 6) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else begin
          cur_word = word_q.pop_front();
          in_valid       <= 1'b1;
          in_req_type    <= cur_word.req_type;
          in_family      <= cur_word.family;
          in_addr_w0     <= cur_word.w0;
          in_addr_w1     <= cur_word.w1;
          in_addr_w2     <= cur_word.w2;
          in_addr_w3     <= cur_word.w3;
          in_port        <= cur_word.port;
          in_entry_index <= cur_word.idx;
          in_entry_addr  <= cur_word.e_addr;
          in_entry_mask  <= cur_word.e_mask;
          in_entry_port  <= cur_word.e_port;
          in_entry_valid <= cur_word.e_valid;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold to back up the block
  int rx_count = 0;
  int rx_gap   = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_count++;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && rx_count >= 300) begin
        hold_done = 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (!tail_mode && ((rx_count / 170) % 4 != 1) && $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: each result word against the oldest expected verdict
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result word with no verdict expected", $time);
        err_cnt++;
      end else begin
        e = verdict_q.pop_front();
        check_field("bypass", 32'(e.bypass), 32'(out_bypass));
        check_field("verdict", 32'(e.verdict), 32'(out_verdict));
        check_field("is_ipv6", 32'(e.is_ipv6), 32'(out_is_ipv6));
        check_field("ipv4_target", e.ipv4_target, out_ipv4_target);
        check_field("port_out", 32'(e.port_out), 32'(out_port_out));
      end
    end
  end

  // watchdog on cycles with no word moving on either port
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("socket_target_bypass_classifier test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [31:0] t;
    logic [15:0] p;
    int          roll;
    int          k;

    // empty table: extremes of the target fields all go to proxy
    add_classify(FAM_IPV4, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    add_classify(FAM_IPV4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 16'hffff);
    // unsupported families, including the unused code
    add_classify(FAM_OTHER, $urandom, $urandom, $urandom, $urandom, 16'd80);
    add_classify(FAM_RSVD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 16'hffff);
    // plain ipv6, the all-zero address, near-mapped forms and one mapped form
    add_classify(FAM_IPV6, $urandom, $urandom, $urandom, $urandom, 16'd443);
    add_classify(FAM_IPV6, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    add_classify(FAM_IPV6, 32'h0, 32'h0, 32'h0000_fffe, 32'h0a01_0203, 16'd80);
    add_classify(FAM_IPV6, 32'h0, 32'h1, MAPPED_MARK, 32'h0a01_0203, 16'd80);
    add_classify(FAM_IPV6, 32'h0, 32'h0, MAPPED_MARK, 32'h0a01_0203, 16'd80);
    // any-port entry, hit right behind the write, also through a mapped address
    add_write(3'd0, 32'h0a00_0000, 32'hff00_0000, 16'h0, 1'b1);
    add_classify(FAM_IPV4, 32'h0a01_0203, $urandom, $urandom, $urandom, 16'd80);
    add_classify(FAM_IPV6, 32'h0, 32'h0, MAPPED_MARK, 32'h0a09_0909, 16'hffff);
    // port-specific entry: right port hits, wrong port misses
    add_write(3'd7, 32'hc0a8_0100, 32'hffff_ff00, 16'd443, 1'b1);
    add_classify(FAM_IPV4, 32'hc0a8_0105, 32'h0, 32'h0, 32'h0, 16'd443);
    add_classify(FAM_IPV4, 32'hc0a8_0105, 32'h0, 32'h0, 32'h0, 16'd444);
    // zero mask matches everything, then the slot is disabled again
    add_write(3'd3, 32'hffff_ffff, 32'h0, 16'h0, 1'b1);
    add_classify(FAM_IPV4, 32'h5555_aaaa, 32'h0, 32'h0, 32'h0, 16'd1);
    add_write(3'd3, 32'hffff_ffff, 32'h0, 16'h0, 1'b0);
    add_classify(FAM_IPV4, 32'h5555_aaaa, 32'h0, 32'h0, 32'h0, 16'd1);
    // full mask and top port: exact hit and single-bit miss
    add_write(3'd5, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b1);
    add_classify(FAM_IPV4, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 16'hffff);
    add_classify(FAM_IPV4, 32'hffff_fffe, 32'h0, 32'h0, 32'h0, 16'hffff);
    // disabling write on a live slot
    add_write(3'd0, 32'h0a00_0000, 32'hff00_0000, 16'h0, 1'b0);
    add_classify(FAM_IPV4, 32'h0a01_0203, 32'h0, 32'h0, 32'h0, 16'd80);

    // random part: aimed targets, mapped targets, ipv6 noise, unsupported families and writes
    for (int n = 0; n < RAND_WORDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        add_write(3'($urandom), $urandom, rand_mask(),
                  ($urandom_range(0, 1) != 0) ? 16'h0 : 16'($urandom),
                  $urandom_range(0, 6) != 0);
      end else if (roll < 55) begin
        aim_target(t, p);
        add_classify(FAM_IPV4, t, $urandom, $urandom, $urandom, p);
      end else if (roll < 75) begin
        aim_target(t, p);
        add_classify(FAM_IPV6, 32'h0, 32'h0, MAPPED_MARK, t, p);
      end else if (roll < 90) begin
        aim_target(t, p);
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0: add_classify(FAM_IPV6, $urandom, $urandom, $urandom, t, p);
          1: add_classify(FAM_IPV6, 32'h0, 32'h0, MAPPED_MARK ^ (32'h1 << k), t, p);
          2: add_classify(FAM_IPV6, 32'h0, 32'h1 << k, MAPPED_MARK, t, p);
          default: add_classify(FAM_IPV6, 32'h1 << k, 32'h0, MAPPED_MARK, t, p);
        endcase
      end else begin
        add_classify(($urandom_range(0, 1) != 0) ? FAM_OTHER : FAM_RSVD,
                     $urandom, $urandom, $urandom, $urandom, 16'($urandom));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all words sent and every verdict seen, then let the pipe settle
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (10) @(posedge clk);

    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("socket_target_bypass_classifier test passed");
    end else begin
      $display("socket_target_bypass_classifier test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/stbc_pkg.sv
rtl/stbc_decode.sv
rtl/stbc_table.sv
rtl/socket_target_bypass_classifier.sv
verif/socket_target_bypass_classifier_tb.sv
